FILE: design/bitpk_pkg.sv
// Package for the MSB-first code bit packer.
// Field widths, default limits and the queue control type shared by all modules.
// No dependencies.
package bitpk_pkg;

    // Field widths of the stream payload
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int VB_W     = 4;
    localparam int TOTAL_W  = 32;
    localparam int PCNT_W   = 3;
    localparam int PEND_W   = 7;
    localparam int NBYTES_W = 4;

    // Default for the longest codeword
    localparam int MAX_CODE_LEN_DEF = 64;

    // Packed port widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    // Valid bit count of a full byte
    localparam logic [VB_W-1:0] FULL_BYTE_BITS = VB_W'(8);

    // Control part of one queue entry
    typedef struct packed {
        logic                flush;
        logic [PCNT_W-1:0]   flush_bits;
        logic [NBYTES_W-1:0] nbytes;
    } bitpk_ctl_t;

    localparam int CTL_W = $bits(bitpk_ctl_t);

endpackage

FILE: design/bitpk_front.sv
// Front part of the packer: accepts items, merges codes with the pending bits
// and hands blocks of full bytes (or a flushed byte) to the queue. Uses bitpk_pkg.
module bitpk_front
    import bitpk_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int BLK_W        = 8 * ((MAX_CODE_LEN + 7) / 8)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic [CODE_W-1:0] code_value,
    input  logic [LEN_W-1:0]  code_length,
    output logic              push,
    output logic [BLK_W-1:0]  blk,
    output bitpk_ctl_t        ctl
);

    localparam int ACC_W = MAX_CODE_LEN + 7;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [PCNT_W-1:0] pcnt_reg;
    logic [PCNT_W-1:0] pcnt_next;

    logic [LEN_W-1:0]    len_sat;
    logic [CODE_W-1:0]   code_masked;
    logic [ACC_W-1:0]    acc;
    logic [LEN_W-1:0]    total;
    logic [PCNT_W-1:0]   cnt_new;
    logic [NBYTES_W-1:0] nbytes;
    logic [BYTE_W-1:0]   flush_byte;

    // Saturate the length and drop stray high bits
    always_comb
    begin
        len_sat     = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;
        code_masked = code_value & ~({CODE_W{1'b1}} << len_sat);
    end

    // Append the code after the pending bits
    always_comb
    begin
        acc     = (ACC_W'(pend_reg) << len_sat) | ACC_W'(code_masked);
        total   = {4'b0, pcnt_reg} + len_sat;
        cnt_new = total[2:0];
        nbytes  = total[6:3];
    end

    // Left-align the pending bits for a flush
    always_comb
    begin
        flush_byte = BYTE_W'(16'({9'b0, pend_reg}) << (4'd8 - {1'b0, pcnt_reg}));
    end

    // Build the queue entry
    always_comb
    begin
        if (mode)
        begin
            blk            = BLK_W'(flush_byte);
            ctl.flush      = 1'b1;
            ctl.flush_bits = pcnt_reg;
            ctl.nbytes     = NBYTES_W'(1);
            push           = accept && (pcnt_reg != '0);
        end
        else
        begin
            blk            = BLK_W'(acc >> cnt_new);
            ctl.flush      = 1'b0;
            ctl.flush_bits = '0;
            ctl.nbytes     = nbytes;
            push           = accept && (nbytes != '0);
        end
    end

    // Next pending state
    always_comb
    begin
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        if (accept)
        begin
            if (mode)
            begin
                pend_next = '0;
                pcnt_next = '0;
            end
            else
            begin
                pend_next = PEND_W'(acc) & ~({PEND_W{1'b1}} << cnt_new);
                pcnt_next = cnt_new;
            end
        end
    end

    // Hold the pending bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

endmodule

FILE: design/bitpk_queue.sv
// Two-entry queue between the front and back parts of the packer.
// Holds byte blocks with their control word. Uses bitpk_pkg.
module bitpk_queue
    import bitpk_pkg::*;
#(
    parameter int W = 72
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         not_empty,
    output logic         full
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/bitpk_back.sv
// Back part of the packer: sends the head queue entry's bytes one per cycle unless
// stalled, via an output register, and keeps the full byte count. Uses bitpk_pkg.
module bitpk_back
    import bitpk_pkg::*;
#(
    parameter int BLK_W = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  logic [BLK_W-1:0]   q_blk,
    input  bitpk_ctl_t         q_ctl,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [VB_W-1:0]    valid_bits,
    output logic               last_of_run,
    output logic [TOTAL_W-1:0] full_byte_total
);

    localparam int BLK_BYTES = BLK_W / 8;

    logic [NBYTES_W-1:0] idx_reg;
    logic [NBYTES_W-1:0] idx_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic                oval_reg;
    logic                oval_next;
    logic [BYTE_W-1:0]   obyte_reg;
    logic [VB_W-1:0]     ovb_reg;
    logic                olast_reg;

    logic                load;
    logic [NBYTES_W-1:0] pos;
    logic [BYTE_W-1:0]   sel_byte;
    logic                is_last;
    logic [VB_W-1:0]     sel_vb;

    // Pick the byte at the current position, first stream byte highest
    always_comb
    begin
        pos      = q_ctl.nbytes - idx_reg - NBYTES_W'(1);
        sel_byte = '0;
        for (int k = 0; k < BLK_BYTES; k++)
        begin
            if (pos == NBYTES_W'(k))
            begin
                sel_byte = q_blk[8*k +: 8];
            end
        end
    end

    // Classify the byte and step through the entry
    always_comb
    begin
        load    = q_valid && (!oval_reg || out_ready);
        is_last = q_ctl.flush || (idx_reg + NBYTES_W'(1) == q_ctl.nbytes);
        sel_vb  = q_ctl.flush ? {1'b0, q_ctl.flush_bits} : FULL_BYTE_BITS;
        pop     = load && is_last;

        idx_next   = idx_reg;
        total_next = total_reg;
        if (load)
        begin
            idx_next = is_last ? '0 : idx_reg + NBYTES_W'(1);
            if (!q_ctl.flush)
            begin
                total_next = total_reg + TOTAL_W'(1);
            end
        end

        oval_next = oval_reg;
        if (load)
        begin
            oval_next = 1'b1;
        end
        else if (out_ready)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            total_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            total_reg <= total_next;
            oval_reg  <= oval_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= sel_byte;
            ovb_reg   <= sel_vb;
            olast_reg <= is_last;
        end
    end

    assign out_valid       = oval_reg;
    assign out_byte        = obyte_reg;
    assign valid_bits      = ovb_reg;
    assign last_of_run     = olast_reg;
    assign full_byte_total = total_reg;

endmodule

FILE: design/msb_first_code_bit_packer.sv
// MSB-first variable-length bit packer. Takes one codeword (0..MAX_CODE_LEN
// bits, right-aligned) or a flush command per input transfer and emits packed
// bytes, first stream bit in bit 7, one byte per output transfer. An input
// transfer is taken every cycle while the two-entry queue between the front
// (bit merge) and back (byte sequencer) has room; the back sends one byte per
// cycle unless m_tready stalls it. An item yields up to 8 bytes for a 64-bit
// code. Codes that complete no byte and empty flushes are accepted but produce
// nothing. Uses bitpk_pkg, bitpk_front, bitpk_queue, bitpk_back.
module msb_first_code_bit_packer
    import bitpk_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // code_value[63:0], code_length[70:64], pad
    input  logic                 s_tuser,   // mode: 0 code, 1 flush
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_byte[7:0], valid_bits[11:8],
                                            // full_byte_total[43:12], pad
    output logic                 m_tlast    // last_of_run
);

    localparam int BLK_W = 8 * ((MAX_CODE_LEN + 7) / 8);
    localparam int Q_W   = BLK_W + CTL_W;

    logic               accept;
    logic               push;
    logic [BLK_W-1:0]   f_blk;
    bitpk_ctl_t         f_ctl;
    logic [Q_W-1:0]     q_rd;
    logic               q_not_empty;
    logic               q_full;
    logic               pop;
    bitpk_ctl_t         b_ctl;
    logic [BLK_W-1:0]   b_blk;
    logic [BYTE_W-1:0]  out_byte;
    logic [VB_W-1:0]    valid_bits;
    logic [TOTAL_W-1:0] full_byte_total;

    // Take an input transfer whenever the queue has room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    bitpk_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .BLK_W        (BLK_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (s_tuser),
        .code_value  (s_tdata[CODE_W-1:0]),
        .code_length (s_tdata[CODE_W+LEN_W-1:CODE_W]),
        .push        (push),
        .blk         (f_blk),
        .ctl         (f_ctl)
    );

    bitpk_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   ({f_blk, f_ctl}),
        .pop       (pop),
        .rd_data   (q_rd),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign b_blk = q_rd[Q_W-1:CTL_W];
    assign b_ctl = q_rd[CTL_W-1:0];

    bitpk_back #(
        .BLK_W (BLK_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_blk           (b_blk),
        .q_ctl           (b_ctl),
        .pop             (pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_byte        (out_byte),
        .valid_bits      (valid_bits),
        .last_of_run     (m_tlast),
        .full_byte_total (full_byte_total)
    );

    // Pack the output payload
    assign m_tdata = {4'b0, full_byte_total, valid_bits, out_byte};

endmodule

FILE: design/bitpk_checker.sv
// Port-level checks for the MSB-first code bit packer, bound to the top level.
// Depends on bitpk_pkg and msb_first_code_bit_packer.
module bitpk_checker
    import bitpk_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // Stalled output holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // A partial byte only ends a run
    a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:8] != FULL_BYTE_BITS) |-> m_tlast)
        else $error("partial byte not marked last");

    // Valid bit count stays within one byte
    a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= 4'd8))
        else $error("valid bit count out of range");

    // Padding bits of a flushed byte are zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[11:8] != FULL_BYTE_BITS)
            |-> ((m_tdata[7:0] & (8'hFF >> m_tdata[11:8])) == 8'h00))
        else $error("flushed byte padding not zero");

endmodule

bind msb_first_code_bit_packer bitpk_checker u_bitpk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for msb_first_code_bit_packer: streams codewords and flushes
// in, predicts every packed byte and compares the output stream against it.
// Depends on bitpk_pkg and the packer RTL.
module testbench;
    import bitpk_pkg::*;

    // Input modes carried on s_tuser
    localparam logic MODE_CODE  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Longest codeword the instance accepts
    localparam int CODE_LEN_MAX = MAX_CODE_LEN_DEF;

    // Cycles without any transfer before the run is abandoned
    localparam int STALL_LIMIT = 5000;

    // Settling cycles after the last expected byte
    localparam int SETTLE_CYCLES = 20;

    // One expected output byte
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [VB_W-1:0]    valid_bits;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } byte_result_t;

    // Bit packing predictor and queue of expected bytes
    class byte_stream_board;
        byte_result_t       expected_bytes[$];
        logic [PEND_W-1:0]  pend_bits;
        int                 pend_cnt;
        logic [TOTAL_W-1:0] full_total;
        int                 errors;

        function new();
            pend_bits  = '0;
            pend_cnt   = 0;
            full_total = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Predict the bytes caused by one accepted input transfer
        function void absorb_item(logic mode, logic [CODE_W-1:0] value, logic [LEN_W-1:0] len);
            byte_result_t e;
            logic [BYTE_W-1:0] cur;
            int n_len;
            int cnt;
            int nres;
            if (mode == MODE_FLUSH) begin
                // Flush emits the pending bits left-aligned, only if there are any
                if (pend_cnt != 0) begin
                    cur = {1'b0, pend_bits} << (8 - pend_cnt);
                    e.out_byte   = cur;
                    e.valid_bits = VB_W'(pend_cnt);
                    e.last       = 1'b1;
                    e.total      = full_total;
                    expected_bytes.insert(expected_bytes.size(), e);
                    pend_bits = '0;
                    pend_cnt  = 0;
                end
                return;
            end
            // Saturate overlong codes; bits at or above the length are never read
            n_len = (int'(len) > CODE_LEN_MAX) ? CODE_LEN_MAX : int'(len);
            cur   = {1'b0, pend_bits};
            cnt   = pend_cnt;
            nres  = 0;
            for (int i = n_len; i > 0; i--) begin
                cur = {cur[BYTE_W-2:0], value[i-1]};
                cnt++;
                if (cnt == 8) begin
                    full_total   = full_total + 1'b1;
                    e.out_byte   = cur;
                    e.valid_bits = FULL_BYTE_BITS;
                    e.last       = 1'b0;
                    e.total      = full_total;
                    expected_bytes.insert(expected_bytes.size(), e);
                    nres++;
                    cur = '0;
                    cnt = 0;
                end
            end
            if (nres > 0)
                expected_bytes[expected_bytes.size()-1].last = 1'b1;
            pend_cnt  = cnt;
            pend_bits = cur[PEND_W-1:0];
        endfunction

        // Compare one output transfer with the oldest expected byte
        function void compare_byte(logic [BYTE_W-1:0] b, logic [VB_W-1:0] vb, logic last,
                                   logic [TOTAL_W-1:0] tot);
            byte_result_t e;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected byte: byte=%h bits=%0d last=%b total=%0d",
                             b, vb, last, tot);
                return;
            end
            e = expected_bytes.pop_front();
            if (e.out_byte !== b || e.valid_bits !== vb || e.last !== last || e.total !== tot)
            begin
                errors++;
                if (errors <= 10)
                    $display({"byte mismatch: exp byte=%h bits=%0d last=%b total=%0d,",
                              " got byte=%h bits=%0d last=%b total=%0d"},
                             e.out_byte, e.valid_bits, e.last, e.total, b, vb, last, tot);
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // code_value[63:0], code_length[70:64], pad
    logic                 s_tuser  = 1'b0; // mode
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // out_byte[7:0], valid_bits[11:8],
                                           // full_byte_total[43:12], pad
    logic                 m_tlast;         // last_of_run

    byte_stream_board board = new();

    bit tx_gaps_on     = 1'b1;
    bit rx_stalls_on   = 1'b1;
    int rx_hold_cycles = 0;
    int idle_cycles    = 0;

    msb_first_code_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one item after an optional gap and hold it until the transfer
    task automatic send_item(input logic mode, input logic [CODE_W-1:0] value,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, len, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Random item: some flushes, lengths biased short, with zero and overlong ones
    task automatic send_random_item();
        int r;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 5)
            len = '0;
        else if (r < 65)
            len = LEN_W'($urandom_range(1, 16));
        else if (r < 90)
            len = LEN_W'($urandom_range(17, 64));
        else
            len = LEN_W'($urandom_range(65, 127));
        send_item(($urandom_range(0, 99) < 12) ? MODE_FLUSH : MODE_CODE,
                  {$urandom, $urandom}, len);
    endtask

    // Drop valid and wait until every expected byte has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : rx_proc
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_stalls_on)
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    m_tready <= 1'b0;
                    stall_left--;
                end
                else
                    m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Record input transfers before checking output transfers of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.absorb_item(s_tuser, s_tdata[CODE_W-1:0],
                                  s_tdata[CODE_W+LEN_W-1:CODE_W]);
            if (m_tvalid && m_tready)
                board.compare_byte(m_tdata[7:0], m_tdata[11:8], m_tlast, m_tdata[43:12]);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: empty code, empty flush, short code and its flush
        send_item(MODE_CODE,  64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_item(MODE_FLUSH, 64'h0, 7'd0);
        send_item(MODE_CODE,  64'hFFFF_FFFF_FFFF_FFF5, 7'd3);
        send_item(MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
        // Full-width codes, all ones and all zeros
        send_item(MODE_CODE,  64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_item(MODE_CODE,  64'h0, 7'd64);
        // Pending bits plus a full code: 69 bits, 8 bytes and 5 left
        send_item(MODE_CODE,  64'h0000_0000_0000_0013, 7'd5);
        send_item(MODE_CODE,  64'h0123_4567_89AB_CDEF, 7'd64);
        send_item(MODE_CODE,  64'h8000_0000_0000_0001, 7'd64);
        send_item(MODE_FLUSH, 64'h0, 7'd0);
        // Overlong lengths saturate
        send_item(MODE_CODE,  64'hDEAD_BEEF_CAFE_F00D, 7'd127);
        send_item(MODE_CODE,  64'h5555_AAAA_3333_CCCC, 7'd65);
        send_item(MODE_CODE,  64'hA5A5_5A5A_0F0F_F0F0, 7'd100);
        // Stray high bits above the length
        send_item(MODE_CODE,  64'hFFFF_FFFF_FFFF_FFA5, 7'd8);
        send_item(MODE_CODE,  64'hFFFF_FFFF_FFFF_FF00, 7'd7);
        send_item(MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        send_item(MODE_CODE,  64'h1, 7'd1);
        send_item(MODE_FLUSH, 64'h0, 7'd0);
        send_item(MODE_FLUSH, 64'h0, 7'd0);
        send_item(MODE_CODE,  64'h7F, 7'd7);
        send_item(MODE_CODE,  64'h1, 7'd1);
        wait_drained();

        // Random items, idling on both sides
        repeat (40) send_random_item();
        wait_drained();

        // Hold off the receiver while the sender streams back to back
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 300;
        repeat (25) send_random_item();
        wait_drained();

        // Stretch with no idling at all
        rx_stalls_on = 1'b0;
        repeat (30) send_random_item();
        wait_drained();

        // Idling again on both sides
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (15) send_random_item();
        wait_drained();

        if (board.errors == 0 && board.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
